// File: hdl/lkvt_pkg.sv
package lkvt_pkg;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_APPEND   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIND_KEY = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_VAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd4;

  // Response status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// File: hdl/kvt_req_if.sv
interface kvt_req_if #(
  parameter int KEY_W  = 32,
  parameter int VAL_W  = 32,
  parameter int SLOT_W = 6
);
  logic                         valid;
  logic                         ready;
  logic [lkvt_pkg::MODE_W-1:0]  mode;
  logic [KEY_W-1:0]             key_in;
  logic [VAL_W-1:0]             value_in;
  logic [SLOT_W-1:0]            slot;

  modport source (output valid, output mode, output key_in, output value_in, output slot,
                  input ready);
  modport sink   (input valid, input mode, input key_in, input value_in, input slot,
                  output ready);
endinterface

// File: hdl/kvt_rsp_if.sv
interface kvt_rsp_if #(
  parameter int KEY_W = 32,
  parameter int VAL_W = 32,
  parameter int CNT_W = 7
);
  logic                          valid;
  logic                          ready;
  logic [lkvt_pkg::STATUS_W-1:0] status;
  logic [KEY_W-1:0]              key_out;
  logic [VAL_W-1:0]              value_out;
  logic [CNT_W-1:0]              entry_count;
  logic [CNT_W-1:0]              removed;

  modport source (output valid, output status, output key_out, output value_out,
                  output entry_count, output removed, input ready);
  modport sink   (input valid, input status, input key_out, input value_out,
                  input entry_count, input removed, output ready);
endinterface

// File: hdl/linear_key_value_table.sv
// Ordered key/value table with linear search.
// req (sink): mode, key_in, value_in, slot. A transaction is taken when valid and
//   ready are both high; ready is high only while the sequencer is idle.
// rsp (source): status, key_out, value_out, entry_count, removed; one response per
//   request, held in an output register until the receiver takes it.
// Sequence: append, read-at-index and unused modes go from idle to the final
//   step and then into the output register; find and remove first scan the
//   filled entries, since the table memory (one read port, one write port) is read
//   one entry a cycle and each entry passes the one shared comparator (a find
//   stops at its first hit). Remove compacts in the same pass, writing kept
//   entries back behind the read pointer. Requests are handled one at a time.
// A new request may be taken while the previous response still waits in the
//   output register; a stalled receiver holds the next result in the final step
//   and the block then takes no further request.
// Reset (rst, synchronous) empties the table and drops any pending response;
//   table contents are not cleared, entries beyond the count are never read.
module linear_key_value_table #(
  parameter int DEPTH = 64,
  parameter int KEY_W = 32,
  parameter int VAL_W = 32
) (
  input  logic       clk,
  input  logic       rst,
  kvt_req_if.sink    req,
  kvt_rsp_if.source  rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (KEY_W > VAL_W) ? KEY_W : VAL_W;

  // Table memory
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [KEY_W-1:0] mem_wkey;
  logic [VAL_W-1:0] mem_wval;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  // Control
  lkvt_pkg::state_t state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] wr_idx, wr_idx_next;
  logic             pend, pend_next;
  logic             take_rd, take_rd_next;
  logic             out_valid, out_valid_next;

  // Request and result payload
  logic [lkvt_pkg::MODE_W-1:0]   op, op_next;
  logic [KEY_W-1:0]              key_q, key_q_next;
  logic [VAL_W-1:0]              val_q, val_q_next;
  logic [lkvt_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [KEY_W-1:0]              res_key, res_key_next;
  logic [VAL_W-1:0]              res_val, res_val_next;
  logic [CNT_W-1:0]              nrem, nrem_next;
  logic [lkvt_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic [KEY_W-1:0]              out_key, out_key_next;
  logic [VAL_W-1:0]              out_val, out_val_next;
  logic [CNT_W-1:0]              out_count, out_count_next;
  logic [CNT_W-1:0]              out_removed, out_removed_next;

  // Shared comparator
  logic [CMP_W-1:0] cmp_a;
  logic [CMP_W-1:0] cmp_b;
  logic             hit;

  logic req_fire;
  logic scan_done;

  assign req.ready = (state == lkvt_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  assign cmp_a = (op == lkvt_pkg::MODE_FIND_VAL) ? CMP_W'(rd_val) : CMP_W'(rd_key);
  assign cmp_b = (op == lkvt_pkg::MODE_FIND_VAL) ? CMP_W'(val_q)  : CMP_W'(key_q);
  assign hit   = (cmp_a == cmp_b);

  assign scan_done = !pend && (rd_idx == fill);

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    rd_idx_next      = rd_idx;
    wr_idx_next      = wr_idx;
    pend_next        = 1'b0;
    take_rd_next     = take_rd;
    out_valid_next   = out_valid && !rsp.ready;
    op_next          = op;
    key_q_next       = key_q;
    val_q_next       = val_q;
    res_status_next  = res_status;
    res_key_next     = res_key;
    res_val_next     = res_val;
    nrem_next        = nrem;
    out_status_next  = out_status;
    out_key_next     = out_key;
    out_val_next     = out_val;
    out_count_next   = out_count;
    out_removed_next = out_removed;
    mem_we           = 1'b0;
    mem_waddr        = fill[IDX_W-1:0];
    mem_wkey         = req.key_in;
    mem_wval         = req.value_in;
    mem_re           = 1'b0;
    mem_raddr        = rd_idx[IDX_W-1:0];

    unique case (state)
      lkvt_pkg::ST_IDLE: begin
        if (req_fire) begin
          op_next         = req.mode;
          key_q_next      = req.key_in;
          val_q_next      = req.value_in;
          res_status_next = lkvt_pkg::STAT_OK;
          res_key_next    = '0;
          res_val_next    = '0;
          nrem_next       = '0;
          take_rd_next    = 1'b0;
          rd_idx_next     = '0;
          wr_idx_next     = '0;
          state_next      = lkvt_pkg::ST_FIN;
          unique case (req.mode)
            lkvt_pkg::MODE_APPEND: begin
              if (fill == CNT_W'(DEPTH)) begin
                res_status_next = lkvt_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                fill_next = CNT_W'(fill + 1'b1);
              end
            end
            lkvt_pkg::MODE_FIND_KEY, lkvt_pkg::MODE_FIND_VAL: begin
              res_status_next = lkvt_pkg::STAT_NOT_FOUND;
              state_next      = lkvt_pkg::ST_SCAN;
            end
            lkvt_pkg::MODE_REMOVE: begin
              state_next = lkvt_pkg::ST_SCAN;
            end
            lkvt_pkg::MODE_READ: begin
              if (CNT_W'(req.slot) < fill) begin
                mem_re       = 1'b1;
                mem_raddr    = IDX_W'(req.slot);
                take_rd_next = 1'b1;
              end else begin
                res_status_next = lkvt_pkg::STAT_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      lkvt_pkg::ST_SCAN: begin
        // Issue the next read while the previous entry is compared
        if (rd_idx != fill) begin
          mem_re      = 1'b1;
          pend_next   = 1'b1;
          rd_idx_next = CNT_W'(rd_idx + 1'b1);
        end
        if (op == lkvt_pkg::MODE_REMOVE) begin
          mem_waddr = wr_idx[IDX_W-1:0];
          mem_wkey  = rd_key;
          mem_wval  = rd_val;
          if (pend) begin
            if (hit) begin
              nrem_next = CNT_W'(nrem + 1'b1);
            end else begin
              mem_we      = 1'b1;
              wr_idx_next = CNT_W'(wr_idx + 1'b1);
            end
          end
          if (scan_done) begin
            fill_next  = wr_idx;
            state_next = lkvt_pkg::ST_FIN;
          end
        end else begin
          if (pend && hit) begin
            res_status_next = lkvt_pkg::STAT_OK;
            res_key_next    = rd_key;
            res_val_next    = rd_val;
            state_next      = lkvt_pkg::ST_FIN;
          end else if (scan_done) begin
            state_next = lkvt_pkg::ST_FIN;
          end
        end
      end

      lkvt_pkg::ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_status_next  = res_status;
          out_key_next     = take_rd ? rd_key : res_key;
          out_val_next     = take_rd ? rd_val : res_val;
          out_count_next   = fill;
          out_removed_next = nrem;
          state_next       = lkvt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lkvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      val_mem[mem_waddr] <= mem_wval;
    end
    if (mem_re) begin
      rd_key <= key_mem[mem_raddr];
      rd_val <= val_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lkvt_pkg::ST_IDLE;
      fill      <= '0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      pend      <= 1'b0;
      take_rd   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      rd_idx    <= rd_idx_next;
      wr_idx    <= wr_idx_next;
      pend      <= pend_next;
      take_rd   <= take_rd_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    key_q       <= key_q_next;
    val_q       <= val_q_next;
    res_status  <= res_status_next;
    res_key     <= res_key_next;
    res_val     <= res_val_next;
    nrem        <= nrem_next;
    out_status  <= out_status_next;
    out_key     <= out_key_next;
    out_val     <= out_val_next;
    out_count   <= out_count_next;
    out_removed <= out_removed_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.key_out     = out_key;
  assign rsp.value_out   = out_val;
  assign rsp.entry_count = out_count;
  assign rsp.removed     = out_removed;

  // Compaction writes must trail the read pointer
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == lkvt_pkg::ST_SCAN) |-> (wr_idx <= rd_idx && rd_idx <= fill))
    else $error("write pointer overtook read pointer");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.mode == lkvt_pkg::MODE_APPEND && fill != CNT_W'(DEPTH))
    |=> (fill == CNT_W'($past(fill) + 1'b1)))
    else $error("append did not grow the table");

  a_find_keeps_fill: assert property (@(posedge clk) disable iff (rst)
    (state == lkvt_pkg::ST_SCAN && op != lkvt_pkg::MODE_REMOVE) |=> $stable(fill))
    else $error("search changed the entry count");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == lkvt_pkg::ST_SCAN && op == lkvt_pkg::MODE_REMOVE && scan_done)
    |=> (CNT_W'(fill + nrem) == $past(fill)))
    else $error("removed and kept entries do not add up");

endmodule

// File: tb/kvt_tb_pkg.sv
package kvt_tb_pkg;

  localparam int TBL_DEPTH = 64;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;

  // modes with no operation behind them
  localparam logic [lkvt_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [lkvt_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [lkvt_pkg::MODE_W-1:0] mode;
    logic [KEY_W-1:0]            key_in;
    logic [VAL_W-1:0]            value_in;
    logic [SLOT_W-1:0]           slot;
  } kvt_req_t;

  typedef struct packed {
    logic [lkvt_pkg::STATUS_W-1:0] status;
    logic [KEY_W-1:0]              key_out;
    logic [VAL_W-1:0]              value_out;
    logic [CNT_W-1:0]              entry_count;
    logic [CNT_W-1:0]              removed;
  } kvt_rsp_t;

  class kvt_scoreboard;
    logic [KEY_W-1:0] keys [TBL_DEPTH];
    logic [VAL_W-1:0] vals [TBL_DEPTH];
    int unsigned      fill;
    kvt_rsp_t         rsp_due [$];
    int unsigned      failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return rsp_due.size();
    endfunction

    // Applies an accepted request to the shadow table and queues its response.
    function void take_request(kvt_req_t r);
      kvt_rsp_t    e;
      int unsigned w;
      e = '0;
      case (r.mode)
        lkvt_pkg::MODE_APPEND: begin
          if (fill >= TBL_DEPTH) begin
            e.status = lkvt_pkg::STAT_FULL;
          end else begin
            keys[fill] = r.key_in;
            vals[fill] = r.value_in;
            fill++;
          end
        end
        lkvt_pkg::MODE_FIND_KEY, lkvt_pkg::MODE_FIND_VAL: begin
          e.status = lkvt_pkg::STAT_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if ((r.mode == lkvt_pkg::MODE_FIND_KEY) ? (keys[i] == r.key_in)
                                                     : (vals[i] == r.value_in)) begin
              e.status    = lkvt_pkg::STAT_OK;
              e.key_out   = keys[i];
              e.value_out = vals[i];
              break;
            end
          end
        end
        lkvt_pkg::MODE_READ: begin
          if (r.slot < fill) begin
            e.key_out   = keys[r.slot];
            e.value_out = vals[r.slot];
          end else begin
            e.status = lkvt_pkg::STAT_RANGE;
          end
        end
        lkvt_pkg::MODE_REMOVE: begin
          // compact in place, survivors keep their order
          w = 0;
          for (int i = 0; i < fill; i++) begin
            if (keys[i] == r.key_in) begin
              e.removed++;
            end else begin
              keys[w] = keys[i];
              vals[w] = vals[i];
              w++;
            end
          end
          fill = w;
        end
        default: ;
      endcase
      e.entry_count = CNT_W'(fill);
      rsp_due.push_back(e);
    endfunction

    function void check_response(kvt_rsp_t got);
      kvt_rsp_t exp;
      if (rsp_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: response with none outstanding: %p", got);
        return;
      end
      exp = rsp_due.pop_front();
      if (got.status !== exp.status || got.key_out !== exp.key_out ||
          got.value_out !== exp.value_out || got.entry_count !== exp.entry_count ||
          got.removed !== exp.removed) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: response mismatch\n  exp: %p\n  got: %p", exp, got);
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = kvt_tb_pkg::TBL_DEPTH;
  localparam int KEY_W       = kvt_tb_pkg::KEY_W;
  localparam int VAL_W       = kvt_tb_pkg::VAL_W;
  localparam int SLOT_W      = kvt_tb_pkg::SLOT_W;
  localparam int CNT_W       = kvt_tb_pkg::CNT_W;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN       = TBL_DEPTH + 16;

  localparam logic [KEY_W-1:0] HOT_WORDS [8] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
    32'h0000_0005, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h7FFF_FFFF
  };

  logic clk;
  logic rst;
  bit   calm;

  kvt_tb_pkg::kvt_scoreboard sb;

  kvt_req_if #(.KEY_W(KEY_W), .VAL_W(VAL_W), .SLOT_W(SLOT_W)) req ();
  kvt_rsp_if #(.KEY_W(KEY_W), .VAL_W(VAL_W), .CNT_W(CNT_W))   rsp ();

  linear_key_value_table #(
    .DEPTH (TBL_DEPTH),
    .KEY_W (KEY_W),
    .VAL_W (VAL_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // receiver: ready drops in short bursts unless the run is in its calm tail
  initial begin
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        rsp.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_response(kvt_tb_pkg::kvt_rsp_t'{rsp.status, rsp.key_out, rsp.value_out,
                                               rsp.entry_count, rsp.removed});
  end

  // Valid is only lowered for a gap, so it is never dropped and raised in one step.
  task automatic send_req(input kvt_tb_pkg::kvt_req_t r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.mode     <= r.mode;
    req.key_in   <= r.key_in;
    req.value_in <= r.value_in;
    req.slot     <= r.slot;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.take_request(r);
  endtask

  // Biased towards words already in the table so finds and removes hit.
  function automatic logic [KEY_W-1:0] pick_word(input bit from_vals);
    int unsigned c;
    c = $urandom_range(0, 3);
    if (c < 2 && sb.fill > 0)
      return from_vals ? sb.vals[$urandom_range(0, sb.fill - 1)]
                       : sb.keys[$urandom_range(0, sb.fill - 1)];
    if (c == 2)
      return HOT_WORDS[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic kvt_tb_pkg::kvt_req_t random_req();
    kvt_tb_pkg::kvt_req_t r;
    int unsigned          pick;
    pick       = $urandom_range(0, 99);
    r.key_in   = pick_word(1'b0);
    r.value_in = pick_word(1'b1);
    if (sb.fill > 0 && $urandom_range(0, 2) != 0)
      r.slot = SLOT_W'($urandom_range(0, (sb.fill < TBL_DEPTH) ? sb.fill : TBL_DEPTH - 1));
    else
      r.slot = SLOT_W'($urandom_range(0, TBL_DEPTH - 1));
    if (pick < 38)      r.mode = lkvt_pkg::MODE_APPEND;
    else if (pick < 53) r.mode = lkvt_pkg::MODE_FIND_KEY;
    else if (pick < 68) r.mode = lkvt_pkg::MODE_FIND_VAL;
    else if (pick < 83) r.mode = lkvt_pkg::MODE_READ;
    else if (pick < 96) r.mode = lkvt_pkg::MODE_REMOVE;
    else                r.mode = lkvt_pkg::MODE_W'($urandom_range(
                                   kvt_tb_pkg::MODE_UNUSED_LO, kvt_tb_pkg::MODE_UNUSED_HI));
    return r;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_req(random_req());
  endtask

  initial begin
    kvt_tb_pkg::kvt_req_t r;
    sb = new();
    calm         = 1'b0;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.mode     <= lkvt_pkg::MODE_APPEND;
    req.key_in   <= '0;
    req.value_in <= '0;
    req.slot     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table corners
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ,     32'h0, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_KEY, 32'h0, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_VAL, 32'h0, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_REMOVE,   32'h0, 32'h0, 6'd0});
    // duplicate keys and extreme words
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_APPEND, 32'h0000_0000, 32'h0000_0000, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_APPEND, 32'h0000_0005, 32'h0000_AAAA, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_APPEND, 32'h0000_0005, 32'h0000_5555, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_APPEND, 32'hFFFF_FFFF, 32'h0000_0001, 6'd0});
    // first match wins
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_KEY, 32'h0000_0005, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_KEY, 32'hFFFF_FFFF, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_KEY, 32'h0000_0007, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_VAL, 32'h0, 32'h0000_5555, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_VAL, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_VAL, 32'h0, 32'h0001_2345, 6'd0});
    // index range edges
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ, 32'h0, 32'h0, 6'd4});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ, 32'h0, 32'h0, 6'd5});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ, 32'h0, 32'h0, 6'd63});
    // remove two, then check the survivors shifted down in order
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ,   32'h0, 32'h0, 6'd1});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_REMOVE, 32'h0000_0009, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{kvt_tb_pkg::MODE_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    6'd63});
    send_req(kvt_tb_pkg::kvt_req_t'{kvt_tb_pkg::MODE_UNUSED_HI, 32'h0, 32'h0, 6'd0});

    send_random(140);

    // let the block go quiet before carrying on
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);

    // fill to capacity, then push against the full table
    while (sb.fill < TBL_DEPTH) begin
      r      = random_req();
      r.mode = lkvt_pkg::MODE_APPEND;
      send_req(r);
    end
    for (int i = 0; i < 3; i++) begin
      r      = random_req();
      r.mode = lkvt_pkg::MODE_APPEND;
      send_req(r);
    end
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ, 32'h0, 32'h0, 6'd63});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_READ, 32'h0, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_KEY, 32'h1234_5678, 32'h0, 6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_FIND_VAL, 32'h0, sb.vals[TBL_DEPTH - 1],
                                    6'd0});
    send_req(kvt_tb_pkg::kvt_req_t'{lkvt_pkg::MODE_REMOVE, sb.keys[TBL_DEPTH - 1], 32'h0,
                                    6'd0});

    send_random(150);
    calm = 1'b1;
    send_random(60);

    req.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: linear_key_value_table.f
hdl/lkvt_pkg.sv
hdl/kvt_req_if.sv
hdl/kvt_rsp_if.sv
hdl/linear_key_value_table.sv
tb/kvt_tb_pkg.sv
tb/tb_top.sv
